@@ design/ez_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ez_pkg
// Shared types and constants for the ellipsoid zone area pipeline.
// ----------------------------------------------------------------------------
package ez_pkg;

	localparam logic signed [31:0] LAT_LIMIT   = 32'sd1509949440;
	localparam logic [26:0]        DEG2RAD_Q32 = 27'd74961321;
	localparam logic [31:0]        LN2_Q32     = 32'd2977044472;
	localparam logic [30:0]        ONE_Q30     = 31'd1073741824;
	localparam logic [63:0]        AREA_MAX    = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0]        AREA_MIN    = 64'h8000_0000_0000_0000;
	localparam logic [31:0]        ECC_RESET   = 32'd351326610;
	localparam logic [62:0]        ZONE_RESET  = 63'd4096;

	localparam logic CFG_ECC  = 1'b0;
	localparam logic CFG_ZONE = 1'b1;

	localparam int SIN_TERMS  = 8;
	localparam int QBITS      = 62;
	localparam int LG_STEPS   = 30;
	localparam int DIV_LAT    = QBITS + 2;
	localparam int LOG_LAT    = LG_STEPS + 4;
	localparam int T2_DLY     = DIV_LAT - LOG_LAT;
	localparam int LAT_DEPTH  = 3 + 3 * SIN_TERMS + 2 + DIV_LAT + 2;
	localparam int CORE_DEPTH = LAT_DEPTH + 7;

	typedef struct packed {
		logic [31:0]        t2;
		logic [30:0]        term;
		logic signed [33:0] s;
	} sin_bus_t;

	typedef struct packed {
		logic [63:0]       r;
		logic [64:0]       d;
		logic [QBITS-1:0]  q;
	} div_bus_t;

	typedef struct packed {
		logic [31:0] y;
		logic [29:0] frac;
		logic [5:0]  p;
	} lg_bus_t;

endpackage
`default_nettype wire

@@ design/ez_sin_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ez_sin_cell
// One Taylor term of the sine series: multiply, divide by constant, accumulate.
// ----------------------------------------------------------------------------
module ez_sin_cell import ez_pkg::*; #(
	parameter int K = 1
) (
	input  logic     clk,
	input  logic     en,
	input  sin_bus_t bin,
	output sin_bus_t bout
);
	localparam int          DIV   = (2 * K) * (2 * K + 1);
	localparam logic [30:0] RECIP = 31'((64'd1 << 33) / DIV);
	localparam logic [32:0] DIV_W = 33'(DIV);
	localparam bit          SUB   = (K % 2) == 1;

	logic [62:0]        prod1;
	logic [63:0]        prod2;
	logic [32:0]        qd;
	logic [32:0]        rem;
	logic [30:0]        qc;
	logic [32:0]        n_s1, n_s2;
	logic [31:0]        t2_s1, t2_s2;
	logic signed [33:0] s_s1, s_s2;
	logic [30:0]        q0_s2;
	sin_bus_t           bout_s3;

	assign prod1 = bin.term * bin.t2;
	assign prod2 = n_s1 * RECIP;
	assign qd    = {2'b00, q0_s2} * DIV_W;
	assign rem   = n_s2 - qd;
	assign qc    = q0_s2 + 31'(rem >= DIV_W);

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1  <= prod1[62:30];
			t2_s1 <= bin.t2;
			s_s1  <= bin.s;
			q0_s2 <= prod2[63:33];
			n_s2  <= n_s1;
			t2_s2 <= t2_s1;
			s_s2  <= s_s1;
			bout_s3.t2   <= t2_s2;
			bout_s3.term <= qc;
			bout_s3.s    <= SUB ? s_s2 - signed'({3'b000, qc}) : s_s2 + signed'({3'b000, qc});
		end
	end

	assign bout = bout_s3;
endmodule
`default_nettype wire

@@ design/ez_div_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ez_div_cell
// One restoring division step, one quotient bit.
// ----------------------------------------------------------------------------
module ez_div_cell import ez_pkg::*; (
	input  logic     clk,
	input  logic     en,
	input  div_bus_t bin,
	output div_bus_t bout
);
	logic [64:0] r2;
	logic [64:0] diff;
	logic        ge;
	div_bus_t    bout_q;

	assign r2   = {bin.r, 1'b0};
	assign ge   = r2 >= bin.d;
	assign diff = r2 - bin.d;

	always_ff @(posedge clk) begin
		if (en) begin
			bout_q.r <= ge ? diff[63:0] : r2[63:0];
			bout_q.d <= bin.d;
			bout_q.q <= {bin.q[QBITS-2:0], ge};
		end
	end

	assign bout = bout_q;
endmodule
`default_nettype wire

@@ design/ez_lg_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ez_lg_cell
// One squaring step of the log2 fraction, one fraction bit.
// ----------------------------------------------------------------------------
module ez_lg_cell import ez_pkg::*; (
	input  logic    clk,
	input  logic    en,
	input  lg_bus_t bin,
	output lg_bus_t bout
);
	logic [63:0] sq;
	logic [32:0] ys;
	lg_bus_t     bout_q;

	assign sq = bin.y * bin.y;
	assign ys = sq[63:31];

	always_ff @(posedge clk) begin
		if (en) begin
			bout_q.y    <= ys[32] ? ys[32:1] : ys[31:0];
			bout_q.frac <= {bin.frac[28:0], ys[32]};
			bout_q.p    <= bin.p;
		end
	end

	assign bout = bout_q;
endmodule
`default_nettype wire

@@ design/ez_lat.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ez_lat
// Per-latitude chain: sine series, x/(1-x^2) divider and atanh log lanes.
// ----------------------------------------------------------------------------
module ez_lat import ez_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] lat,
	input  logic [31:0]        ecc,
	output logic [63:0]        g
);
	localparam logic signed [31:0] LAT_NEG = -LAT_LIMIT;

	function automatic logic [5:0] msb33(input logic [32:0] v);
		logic [5:0] p;
		p = '0;
		for (int i = 0; i < 33; i++) begin
			if (v[i]) p = 6'(i);
		end
		return p;
	endfunction

	logic signed [31:0] lat_c;
	logic [31:0]        lat_abs;
	logic [LAT_DEPTH-2:0] neg_q;
	logic [30:0]        a_s1;
	logic [57:0]        th_prod;
	logic [30:0]        theta_s2;
	logic [61:0]        thsq;
	sin_bus_t           sin_b [SIN_TERMS+1];
	logic [30:0]        sc_s28;
	logic [64:0]        x_prod;
	logic [31:0]        x_s29;
	logic [63:0]        xsq_s30;
	logic [31:0]        xd_s30;
	div_bus_t           div_b [QBITS+1];
	logic [32:0]        v2;
	logic [32:0]        v2_s30;
	logic [5:0]         p2_s30;
	logic [31:0]        xl_s30;
	logic [63:0]        sh;
	lg_bus_t            lga_b [LG_STEPS+1];
	lg_bus_t            lgb_b [LG_STEPS+1];
	logic [36:0]        ldiff;
	logic [35:0]        l_s62;
	logic [67:0]        t2_prod;
	logic [34:0]        t2_s63;
	logic [34:0]        t2_dly_q [T2_DLY];
	logic [63:0]        sum_s94;
	logic [63:0]        g_s95;

	always_comb begin
		lat_c = lat;
		if (lat > LAT_LIMIT) lat_c = LAT_LIMIT;
		else if (lat < LAT_NEG) lat_c = LAT_NEG;
	end

	assign lat_abs = lat_c[31] ? 32'(-lat_c) : 32'(lat_c);
	assign th_prod = a_s1 * DEG2RAD_Q32;
	assign thsq    = theta_s2 * theta_s2;
	assign x_prod  = ecc * {sc_s28, 2'b00};
	assign v2      = 33'h1_0000_0000 - {1'b0, x_s29};

	always_comb begin
		if (p2_s30 >= 6'd31) sh = {31'b0, v2_s30} >> (p2_s30 - 6'd31);
		else sh = {31'b0, v2_s30} << (6'd31 - p2_s30);
	end

	assign ldiff   = {1'b0, lga_b[LG_STEPS].p[5:0] - 6'd0, lga_b[LG_STEPS].frac}
		- {1'b0, lgb_b[LG_STEPS].p, lgb_b[LG_STEPS].frac};
	assign t2_prod = l_s62 * LN2_Q32;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_q    <= {neg_q[LAT_DEPTH-3:0], lat[31]};
			a_s1     <= lat_abs[30:0];
			theta_s2 <= th_prod[56:26];
			sin_b[0].t2   <= thsq[61:30];
			sin_b[0].term <= theta_s2;
			sin_b[0].s    <= signed'({3'b000, theta_s2});
			if (sin_b[SIN_TERMS].s < 0) sc_s28 <= '0;
			else if (sin_b[SIN_TERMS].s > signed'({3'b000, ONE_Q30})) sc_s28 <= ONE_Q30;
			else sc_s28 <= sin_b[SIN_TERMS].s[30:0];
			x_s29   <= x_prod[63:32];
			xsq_s30 <= x_s29 * x_s29;
			xd_s30  <= x_s29;
			div_b[0].r <= {32'b0, xd_s30};
			div_b[0].d <= 65'h1_0000_0000_0000_0000 - {1'b0, xsq_s30};
			div_b[0].q <= '0;
			v2_s30 <= v2;
			p2_s30 <= msb33(v2);
			xl_s30 <= x_s29;
			lga_b[0].y    <= {1'b1, xl_s30[31:1]};
			lga_b[0].frac <= '0;
			lga_b[0].p    <= 6'd32;
			lgb_b[0].y    <= sh[31:0];
			lgb_b[0].frac <= '0;
			lgb_b[0].p    <= p2_s30;
			l_s62   <= ldiff[36] ? '0 : ldiff[35:0];
			t2_s63  <= t2_prod[67:33];
			t2_dly_q[0] <= t2_s63;
			for (int i = 1; i < T2_DLY; i++) t2_dly_q[i] <= t2_dly_q[i-1];
			sum_s94 <= {2'b00, div_b[QBITS].q} + {29'b0, t2_dly_q[T2_DLY-1]};
			g_s95   <= neg_q[LAT_DEPTH-2] ? -sum_s94 : sum_s94;
		end
	end

	for (genvar k = 1; k <= SIN_TERMS; k++) begin : g_sin
		ez_sin_cell #(.K(k)) u_cell (
			.clk  (clk),
			.en   (en),
			.bin  (sin_b[k-1]),
			.bout (sin_b[k])
		);
	end

	for (genvar j = 0; j < QBITS; j++) begin : g_div
		ez_div_cell u_cell (
			.clk  (clk),
			.en   (en),
			.bin  (div_b[j]),
			.bout (div_b[j+1])
		);
	end

	for (genvar j = 0; j < LG_STEPS; j++) begin : g_lg
		ez_lg_cell u_cell_a (
			.clk  (clk),
			.en   (en),
			.bin  (lga_b[j]),
			.bout (lga_b[j+1])
		);
		ez_lg_cell u_cell_b (
			.clk  (clk),
			.en   (en),
			.bin  (lgb_b[j]),
			.bout (lgb_b[j+1])
		);
	end

	assign g = g_s95;
endmodule
`default_nettype wire

@@ design/ellipsoid_zone_area_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ellipsoid_zone_area_top
// Zone area of an ellipsoid between two latitudes, fully pipelined.
//
//   channel   signals                          carries
//   s_*       s_tvalid s_tready s_tdata[63:0]  latitude pair request
//   m_*       m_tvalid m_tready m_tdata m_tuser area and saturation flag
//   cfg_*     cfg_valid cfg_ready cfg_index    eccentricity / zone factor write
//
// one request per cycle while s_tready is high
// depth is set by the 62-step divider chain for x/(1-x^2) per latitude
// reset clears valid bits and loads default eccentricity and zone factor
// an output register plus one skid slot; s_tready drops while the skid is full
// and the whole chain freezes until m_tready drains it
// ----------------------------------------------------------------------------
module ellipsoid_zone_area_top import ez_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // north_lat[31:0], south_lat[63:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // zone_area[63:0]
	output logic        m_tuser,   // saturated[0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data
);
	logic [31:0]           ecc_q;
	logic [62:0]           zone_q;
	logic                  en;
	logic [CORE_DEPTH-1:0] vld_q;
	logic [63:0]           g_n, g_s;
	logic [63:0]           d_s1;
	logic                  neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	logic [63:0]           mag_s2;
	logic [63:0]           p00_s3, p01_s3;
	logic [62:0]           p10_s3, p11_s3, p10_s4;
	logic [127:0]          acc_s4, acc_s5, acc_s6;
	logic [63:0]           area_s7;
	logic                  sat_s7;
	logic [63:0]           area_c;
	logic                  sat_c;
	logic [63:0]           qv;
	logic [63:0]           out_q, skid_q;
	logic                  outsat_q, skidsat_q;
	logic                  ov_q, kv_q;
	logic                  cv, push, pop;

	assign cfg_ready = 1'b1;
	assign en        = !kv_q;
	assign s_tready  = en;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ecc_q  <= ECC_RESET;
			zone_q <= ZONE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ECC:  ecc_q  <= cfg_data[31:0];
				CFG_ZONE: zone_q <= cfg_data[62:0];
				default:  ecc_q  <= ecc_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[CORE_DEPTH-2:0], s_tvalid};
		end
	end

	ez_lat u_north (
		.clk (clk),
		.en  (en),
		.lat (signed'(s_tdata[31:0])),
		.ecc (ecc_q),
		.g   (g_n)
	);

	ez_lat u_south (
		.clk (clk),
		.en  (en),
		.lat (signed'(s_tdata[63:32])),
		.ecc (ecc_q),
		.g   (g_s)
	);

	assign qv = acc_s6[93:30];

	always_comb begin
		sat_c  = 1'b0;
		area_c = qv;
		if (|acc_s6[127:94]) begin
			sat_c  = 1'b1;
			area_c = neg_s6 ? AREA_MIN : AREA_MAX;
		end else if (!neg_s6) begin
			if (qv[63]) begin
				sat_c  = 1'b1;
				area_c = AREA_MAX;
			end
		end else if (qv > AREA_MIN) begin
			sat_c  = 1'b1;
			area_c = AREA_MIN;
		end else begin
			area_c = -qv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1    <= g_n - g_s;
			neg_s2  <= d_s1[63];
			mag_s2  <= d_s1[63] ? -d_s1 : d_s1;
			p00_s3  <= zone_q[31:0] * mag_s2[31:0];
			p01_s3  <= zone_q[31:0] * mag_s2[63:32];
			p10_s3  <= zone_q[62:32] * mag_s2[31:0];
			p11_s3  <= zone_q[62:32] * mag_s2[63:32];
			neg_s3  <= neg_s2;
			acc_s4  <= {1'b0, p11_s3, p00_s3} + {32'b0, p01_s3, 32'b0};
			p10_s4  <= p10_s3;
			neg_s4  <= neg_s3;
			acc_s5  <= acc_s4 + {33'b0, p10_s4, 32'b0};
			neg_s5  <= neg_s4;
			acc_s6  <= acc_s5 + 128'h2000_0000;
			neg_s6  <= neg_s5;
			area_s7 <= area_c;
			sat_s7  <= sat_c;
		end
	end

	// output register and skid slot
	assign cv   = vld_q[CORE_DEPTH-1];
	assign push = cv && en;
	assign pop  = ov_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			kv_q <= 1'b0;
		end else if (kv_q) begin
			if (pop) kv_q <= 1'b0;
		end else if (push) begin
			if (ov_q && !pop) kv_q <= 1'b1;
			ov_q <= 1'b1;
		end else if (pop) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (kv_q) begin
			if (pop) begin
				out_q    <= skid_q;
				outsat_q <= skidsat_q;
			end
		end else if (push) begin
			if (!ov_q || pop) begin
				out_q    <= area_s7;
				outsat_q <= sat_s7;
			end else begin
				skid_q    <= area_s7;
				skidsat_q <= sat_s7;
			end
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = out_q;
	assign m_tuser  = outsat_q;

`ifndef SYNTHESIS
	a_skid_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		kv_q |-> ov_q) else $error("skid slot full with empty output register");

	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata == AREA_MAX || m_tdata == AREA_MIN))
		else $error("saturated result not at a range limit");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(kv_q) |-> $past(ov_q) && !$past(m_tready))
		else $error("skid filled without a blocked output");
`endif
endmodule
`default_nettype wire

@@ verif/tb_ellipsoid_zone_area_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ellipsoid_zone_area_top
// Self-checking bench for the ellipsoid zone area pipeline. Latitude pairs go
// in over the slave stream with random gaps, results are drained with random
// back-pressure and compared against a bit-accurate fixed-point predictor,
// under several eccentricity / zone factor settings including the extremes.
// ----------------------------------------------------------------------------
module tb_ellipsoid_zone_area_top;
	import ez_pkg::*;

	typedef struct packed {
		logic [63:0] area;
		logic        sat;
	} zone_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_ECC;
	logic [63:0] cfg_data = '0;

	ellipsoid_zone_area_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	logic [31:0]  ecc_model = ECC_RESET;
	logic [62:0]  zone_model = ZONE_RESET;
	zone_result_t area_q[$];
	int           errors = 0;
	int           n_checked = 0;
	int           n_sat = 0;
	int           n_sent = 0;
	int           pending_gap = 1;
	int           stall_cnt = 0;
	bit           no_idle = 0;
	longint       cycles = 0;

	function automatic logic [63:0] sine_q30(logic [63:0] t);
		logic [63:0]        t2;
		logic [63:0]        term;
		logic signed [63:0] s;
		t2 = (t * t) >> 30;
		term = t;
		s = t;
		for (int k = 1; k <= 8; k++) begin
			term = (term * t2) >> 30;
			term = term / 64'((2 * k) * (2 * k + 1));
			if (k & 1) s = s - term;
			else s = s + term;
		end
		if (s < 0) s = 0;
		if (s > 64'(ONE_Q30)) s = 64'(ONE_Q30);
		return s;
	endfunction

	function automatic logic [63:0] log2_q30(logic [63:0] v);
		int          p;
		logic [63:0] y;
		logic [63:0] frac;
		p = 63;
		frac = 0;
		while (p > 0 && v[p] == 1'b0) p--;
		y = (p >= 31) ? (v >> (p - 31)) : (v << (31 - p));
		for (int i = 29; i >= 0; i--) begin
			y = (y * y) >> 31;
			if (y >= 64'h1_0000_0000) begin
				y = y >> 1;
				frac[i] = 1'b1;
			end
		end
		return (64'(p) << 30) + frac;
	endfunction

	function automatic logic [63:0] lat_term_q30(logic [31:0] f);
		logic signed [63:0] lat;
		logic               neg;
		logic [63:0]        a, theta, s, x, t1, g;
		logic signed [63:0] lgd;
		logic [127:0]       num, den, prod;
		lat = $signed(f);
		neg = lat < 0;
		if (lat > 64'(LAT_LIMIT)) lat = 64'(LAT_LIMIT);
		if (lat < -64'(LAT_LIMIT)) lat = -64'(LAT_LIMIT);
		a = neg ? -lat : lat;
		theta = (a * 64'(DEG2RAD_Q32)) >> 26;
		s = sine_q30(theta);
		x = (64'(ecc_model) * (s << 2)) >> 32;
		t1 = 0;
		if (x != 0) begin
			num = 128'(x) << 62;
			den = 128'(64'(64'd0 - x * x));
			t1 = 64'(num / den);
		end
		lgd = log2_q30(64'h1_0000_0000 + x) - log2_q30(64'h1_0000_0000 - x);
		if (lgd < 0) lgd = 0;
		prod = 128'(lgd) * 128'(LN2_Q32);
		g = t1 + prod[96:33];
		return neg ? -g : g;
	endfunction

	function automatic zone_result_t predict_zone_area(logic [31:0] north, logic [31:0] south);
		logic [63:0]  d, mag, q;
		logic         neg;
		logic [127:0] prod;
		zone_result_t r;
		d = lat_term_q30(north) - lat_term_q30(south);
		neg = d[63];
		mag = neg ? -d : d;
		prod = 128'(zone_model) * 128'(mag) + (128'd1 << 29);
		r.sat = 1'b0;
		if (prod[127:94] != 0) begin
			r.sat = 1'b1;
			r.area = neg ? AREA_MIN : AREA_MAX;
		end else begin
			q = prod[93:30];
			if (!neg) begin
				if (q > AREA_MAX) begin
					r.sat = 1'b1;
					q = AREA_MAX;
				end
				r.area = q;
			end else begin
				if (q > AREA_MIN) begin
					r.sat = 1'b1;
					q = AREA_MIN;
				end
				r.area = -q;
			end
		end
		return r;
	endfunction

	// result checker and back-pressure
	always @(posedge clk) begin
		zone_result_t e;
		cycles <= cycles + 1;
		if (m_tvalid && m_tready) begin
			if (area_q.size() == 0) begin
				$display("%0t: unexpected result area=%h sat=%b", $time, m_tdata, m_tuser);
				errors++;
			end else begin
				e = area_q.pop_front();
				n_checked++;
				if (e.sat) n_sat++;
				if (m_tdata !== e.area) begin
					$display("%0t: zone_area mismatch expected %h actual %h",
						$time, e.area, m_tdata);
					errors++;
				end
				if (m_tuser !== e.sat) begin
					$display("%0t: saturated mismatch expected %b actual %b",
						$time, e.sat, m_tuser);
					errors++;
				end
			end
			stall_cnt = no_idle ? 0 : $urandom_range(0, 15);
		end
		if (stall_cnt > 0) begin
			stall_cnt--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (cycles > 3000000) begin
			$display("%0t: timeout with %0d results outstanding", $time, area_q.size());
			$display("ellipsoid_zone_area_top regression: fail");
			$finish;
		end
	end

	task automatic send_pair(input logic [31:0] north, input logic [31:0] south);
		s_tvalid <= 1'b1;
		s_tdata <= {south, north};
		do @(posedge clk); while (!s_tready);
		area_q.push_back(predict_zone_area(north, south));
		n_sent++;
		pending_gap = no_idle ? 0 : $urandom_range(0, 15);
		if (pending_gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (pending_gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		if (pending_gap == 0) s_tvalid <= 1'b0;
		pending_gap = 1;
		while (area_q.size() != 0) @(posedge clk);
	endtask

	task automatic set_config(input logic [31:0] ecc, input logic [62:0] zone);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_index <= CFG_ECC;
		cfg_data <= {32'h0, ecc};
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_ZONE;
		cfg_data <= {1'b0, zone};
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		ecc_model = ecc;
		zone_model = zone;
	endtask

	function automatic logic [31:0] rand_lat();
		int unsigned sel;
		sel = $urandom_range(0, 19);
		if (sel == 0) return $urandom;
		if (sel == 1) return $urandom_range(0, 1) ? LAT_LIMIT : -LAT_LIMIT;
		if (sel == 2) return $urandom_range(0, 4096) - 2048;
		return $urandom_range(0, 2 * LAT_LIMIT) - LAT_LIMIT;
	endfunction

	task automatic test_directed_at_reset();
		logic [31:0] lats[10];
		lats = '{32'h0, LAT_LIMIT, -LAT_LIMIT, 32'h7fff_ffff, 32'h8000_0000,
			32'h1, 32'hffff_ffff, LAT_LIMIT + 1, -LAT_LIMIT - 1, 32'h2d00_0000};
		for (int i = 0; i < 10; i++) send_pair(lats[i], lats[9 - i]);
		send_pair(LAT_LIMIT, -LAT_LIMIT);
		send_pair(-LAT_LIMIT, LAT_LIMIT);
	endtask

	task automatic test_extreme_config();
		set_config(32'hffff_ffff, 63'h7fff_ffff_ffff_ffff);
		send_pair(LAT_LIMIT, -LAT_LIMIT);
		send_pair(-LAT_LIMIT, LAT_LIMIT);
		send_pair(32'h0100_0000, 32'h0);
		send_pair(32'h0, 32'h0);
		set_config(32'hffff_ffff, 63'd1);
		send_pair(LAT_LIMIT, -LAT_LIMIT);
		send_pair(32'h0100_0000, 32'hff00_0000);
	endtask

	task automatic test_zero_eccentricity();
		set_config(32'h0, 63'h7fff_ffff_ffff_ffff);
		send_pair(LAT_LIMIT, -LAT_LIMIT);
		send_pair(32'h1e00_0000, 32'hf000_0000);
		set_config(32'd1, 63'd1);
		send_pair(LAT_LIMIT, -LAT_LIMIT);
	endtask

	task automatic test_random_phases();
		logic [31:0] ecc;
		logic [62:0] zone;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: ecc = ECC_RESET;
				1: ecc = $urandom;
				2: ecc = 32'hffff_ffff - $urandom_range(0, 65535);
				default: ecc = $urandom_range(1, 1 << 20);
			endcase
			case (ph % 3)
				0: zone = ZONE_RESET;
				1: zone = 63'({$urandom, $urandom} >> $urandom_range(1, 63));
				default: zone = 63'({$urandom, $urandom});
			endcase
			if (zone == 0) zone = 1;
			set_config(ecc, zone);
			no_idle = (ph == 3 || ph == 6);
			repeat (250) send_pair(rand_lat(), rand_lat());
			no_idle = 0;
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_at_reset();
		test_extreme_config();
		test_zero_eccentricity();
		test_random_phases();
		drain_results();
		repeat (150) @(posedge clk);
		$display("sent %0d latitude pairs, checked %0d areas (%0d saturated)",
			n_sent, n_checked, n_sat);
		$display("covered reset, extreme, zero and random register settings");
		if (errors == 0 && area_q.size() == 0) begin
			$display("ellipsoid_zone_area_top regression: pass");
		end else begin
			$display("ellipsoid_zone_area_top regression: fail");
		end
		$finish;
	end

endmodule

@@ files.f @@
design/ez_pkg.sv
design/ez_sin_cell.sv
design/ez_div_cell.sv
design/ez_lg_cell.sv
design/ez_lat.sv
design/ellipsoid_zone_area_top.sv
verif/tb_ellipsoid_zone_area_top.sv
